[hdl/ljpf_pkg.sv]
// ----------------------------------------------------------------------------
// ljpf_pkg
// Shared constants, types and helpers for the pair force block.
// ----------------------------------------------------------------------------
package ljpf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int POS_W     = 24;
	localparam int DIFF_W    = 26;
	localparam int SQ_W      = 52;
	localparam int SUM_W     = 54;
	localparam int QUO_W     = 33;
	localparam int ADDR_W    = 5;
	localparam int Q_DEPTH   = 4;
	localparam int QPTR_W    = 2;

	localparam logic [ADDR_W-1:0] REG_BOX        = 5'd0;
	localparam logic [ADDR_W-1:0] REG_CUTOFF     = 5'd4;
	localparam logic [ADDR_W-1:0] REG_STRENGTH   = 5'd8;
	localparam logic [ADDR_W-1:0] REG_POT_SHIFT  = 5'd12;
	localparam logic [ADDR_W-1:0] REG_GRAD_SHIFT = 5'd16;

	localparam logic [23:0] BOX_RESET        = 24'd655360;
	localparam logic [30:0] CUTOFF_RESET     = 31'd409600;
	localparam logic [30:0] STRENGTH_RESET   = 31'd327680;
	localparam logic [31:0] POT_SHIFT_RESET  = 32'hFFFF_EB1D;
	localparam logic [31:0] GRAD_SHIFT_RESET = 32'd5112;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [23:0] first_x;
		logic [23:0] first_y;
		logic [23:0] first_z;
		logic [23:0] second_x;
		logic [23:0] second_y;
		logic [23:0] second_z;
		logic        same_molecule;
	} pair_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic signed [31:0] pair_energy;
		logic               interacts;
		logic               saturated;
	} result_t;

	// Classified pair handed from the front end to the force pipeline.
	typedef struct packed {
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic signed [DIFF_W-1:0] dz;
		logic [SUM_W-1:0]         sum;
		logic                     skip;
	} work_t;

	typedef struct packed {
		logic [23:0] box_size;
		logic [30:0] cutoff_sq;
		logic [30:0] strength;
		logic signed [31:0] pot_shift;
		logic signed [31:0] grad_shift;
	} cfg_t;

	// Clip a 66-bit signed value to 32 bits, setting sat on a clip.
	function automatic logic [32:0] clip32(input logic signed [65:0] v);
		logic [32:0] r;
		if (v > 66'(S32_MAX)) r = {1'b1, S32_MAX};
		else if (v < 66'(S32_MIN)) r = {1'b1, S32_MIN};
		else r = {1'b0, v[31:0]};
		return r;
	endfunction

	// Fixed-point product truncated toward zero, then clipped.
	function automatic logic [32:0] fxmul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		logic [63:0] mag;
		logic signed [65:0] r;
		p = a * b;
		mag = p[63] ? 64'(-p) : 64'(p);
		mag = mag >> FRAC_BITS;
		r = p[63] ? -66'(mag) : 66'(mag);
		return clip32(r);
	endfunction

endpackage

[hdl/ljpf_stream_if.sv]
// ----------------------------------------------------------------------------
// ljpf_stream_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface ljpf_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/lj_pair_force_min_image.sv]
// ----------------------------------------------------------------------------
// lj_pair_force_min_image
// Shifted Lennard-Jones pair force with periodic minimum image, Q16.16.
// ----------------------------------------------------------------------------
// One pair is accepted per cycle and one result leaves per cycle while the
// result is not back-pressured. A pair passes through the classifier (fold,
// then squares and cutoff test), the four-entry queue and the force pipeline,
// whose length is set by the reciprocal of r2 at two quotient bits a stage.
// Back-pressure on the result stalls the force pipeline while the queue and
// classifier keep accepting until the queue fills.
module lj_pair_force_min_image (
	input  logic clk,
	input  logic arst_n,
	ljpf_stream_if.sink   pair_in,
	ljpf_stream_if.source result_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [ljpf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	ljpf_pkg::cfg_t cfg;
	ljpf_stream_if #(.T(ljpf_pkg::work_t)) cls_ch ();
	ljpf_stream_if #(.T(ljpf_pkg::work_t)) q_ch ();

	ljpf_cfg u_cfg (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg);
	ljpf_front u_front (.clk, .arst_n, .cfg, .in_ch(pair_in), .out_ch(cls_ch));
	ljpf_fifo u_fifo (.clk, .arst_n, .in_ch(cls_ch), .out_ch(q_ch));
	ljpf_back u_back (.clk, .arst_n, .cfg, .in_ch(q_ch), .out_ch(result_out));
endmodule

[hdl/ljpf_cfg.sv]
// ----------------------------------------------------------------------------
// ljpf_cfg
// APB register file for box, cutoff, strength and the two shift values.
// ----------------------------------------------------------------------------
module ljpf_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [ljpf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output ljpf_pkg::cfg_t cfg
);
	ljpf_pkg::cfg_t cfg_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_size   <= ljpf_pkg::BOX_RESET;
			cfg_q.cutoff_sq  <= ljpf_pkg::CUTOFF_RESET;
			cfg_q.strength   <= ljpf_pkg::STRENGTH_RESET;
			cfg_q.pot_shift  <= ljpf_pkg::POT_SHIFT_RESET;
			cfg_q.grad_shift <= ljpf_pkg::GRAD_SHIFT_RESET;
		end else if (wr) begin
			unique case (paddr)
				ljpf_pkg::REG_BOX:        cfg_q.box_size   <= pwdata[23:0];
				ljpf_pkg::REG_CUTOFF:     cfg_q.cutoff_sq  <= pwdata[30:0];
				ljpf_pkg::REG_STRENGTH:   cfg_q.strength   <= pwdata[30:0];
				ljpf_pkg::REG_POT_SHIFT:  cfg_q.pot_shift  <= pwdata;
				ljpf_pkg::REG_GRAD_SHIFT: cfg_q.grad_shift <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			ljpf_pkg::REG_BOX:        prdata = {8'd0, cfg_q.box_size};
			ljpf_pkg::REG_CUTOFF:     prdata = {1'b0, cfg_q.cutoff_sq};
			ljpf_pkg::REG_STRENGTH:   prdata = {1'b0, cfg_q.strength};
			ljpf_pkg::REG_POT_SHIFT:  prdata = cfg_q.pot_shift;
			ljpf_pkg::REG_GRAD_SHIFT: prdata = cfg_q.grad_shift;
			default:                  prdata = 32'd0;
		endcase
	end
endmodule

[hdl/ljpf_front.sv]
// ----------------------------------------------------------------------------
// ljpf_front
// Minimum-image fold, sum of squares and cutoff or same-molecule classification, two stages.
// ----------------------------------------------------------------------------
module ljpf_front (
	input  logic clk,
	input  logic arst_n,
	input  ljpf_pkg::cfg_t cfg,
	ljpf_stream_if.sink   in_ch,
	ljpf_stream_if.source out_ch
);
	logic v_s1, v_s2;
	logic adv1, adv2;
	logic signed [ljpf_pkg::DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic same_s1;
	ljpf_pkg::work_t w_s2;

	function automatic logic signed [ljpf_pkg::DIFF_W-1:0] fold(
		input logic [23:0] a, input logic [23:0] b, input logic [23:0] box);
		logic signed [ljpf_pkg::DIFF_W-1:0] d, l;
		d = $signed({2'b00, b}) - $signed({2'b00, a});
		l = $signed({2'b00, box});
		if ((d <<< 1) >= l) d = d - l;
		else if ((d <<< 1) <= -l) d = d + l;
		return d;
	endfunction

	assign adv2 = !v_s2 || out_ch.ready;
	assign adv1 = !v_s1 || adv2;
	assign in_ch.ready = adv1;
	assign out_ch.valid = v_s2;
	assign out_ch.data = w_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_ch.valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_ch.valid) begin
			dx_s1 <= fold(in_ch.data.first_x, in_ch.data.second_x, cfg.box_size);
			dy_s1 <= fold(in_ch.data.first_y, in_ch.data.second_y, cfg.box_size);
			dz_s1 <= fold(in_ch.data.first_z, in_ch.data.second_z, cfg.box_size);
			same_s1 <= in_ch.data.same_molecule;
		end
	end

	logic [ljpf_pkg::SQ_W-1:0] sqx, sqy, sqz;
	logic [ljpf_pkg::SUM_W-1:0] sum;
	always_comb begin
		sqx = ljpf_pkg::SQ_W'(dx_s1 * dx_s1);
		sqy = ljpf_pkg::SQ_W'(dy_s1 * dy_s1);
		sqz = ljpf_pkg::SQ_W'(dz_s1 * dz_s1);
		sum = ljpf_pkg::SUM_W'(sqx) + ljpf_pkg::SUM_W'(sqy) + ljpf_pkg::SUM_W'(sqz);
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			w_s2.dx <= dx_s1;
			w_s2.dy <= dy_s1;
			w_s2.dz <= dz_s1;
			w_s2.sum <= sum;
			w_s2.skip <= same_s1 ||
				(sum > (ljpf_pkg::SUM_W'(cfg.cutoff_sq) << ljpf_pkg::FRAC_BITS));
		end
	end
endmodule

[hdl/ljpf_fifo.sv]
// ----------------------------------------------------------------------------
// ljpf_fifo
// Short queue decoupling the classifier from the force pipeline.
// ----------------------------------------------------------------------------
module ljpf_fifo (
	input  logic clk,
	input  logic arst_n,
	ljpf_stream_if.sink   in_ch,
	ljpf_stream_if.source out_ch
);
	ljpf_pkg::work_t mem [ljpf_pkg::Q_DEPTH];
	logic [ljpf_pkg::QPTR_W-1:0] wp_q, rp_q;
	logic [ljpf_pkg::QPTR_W:0] cnt_q;
	logic push, pop;

	assign in_ch.ready = cnt_q != (ljpf_pkg::QPTR_W+1)'(ljpf_pkg::Q_DEPTH);
	assign out_ch.valid = cnt_q != '0;
	assign out_ch.data = mem[rp_q];
	assign push = in_ch.valid && in_ch.ready;
	assign pop = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk) begin
		if (push) mem[wp_q] <= in_ch.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == (ljpf_pkg::QPTR_W+1)'(ljpf_pkg::Q_DEPTH) |-> !push)
		else $error("queue written while full");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (ljpf_pkg::QPTR_W+1)'(ljpf_pkg::Q_DEPTH))
		else $error("queue count out of range");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not follow a push");
endmodule

[hdl/ljpf_back.sv]
// ----------------------------------------------------------------------------
// ljpf_back
// Force pipeline: reciprocal, powers of q, energy, gradient and forces.
// ----------------------------------------------------------------------------
module ljpf_back (
	input  logic clk,
	input  logic arst_n,
	input  ljpf_pkg::cfg_t cfg,
	ljpf_stream_if.sink   in_ch,
	ljpf_stream_if.source out_ch
);
	localparam int NDIV = 17;      // reciprocal stages, two quotient bits each
	localparam int NST  = NDIV + 9;
	localparam int N = 2 * ljpf_pkg::FRAC_BITS + 1;

	logic [NST-1:0] v;
	logic adv;
	assign adv = !v[NST-1] || out_ch.ready;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v <= '0;
		else if (adv) v <= {v[NST-2:0], in_ch.valid};
	end

	typedef logic signed [ljpf_pkg::DIFF_W-1:0] d_t;
	d_t dx [NST], dy [NST], dz [NST];
	logic skip [NST];

	// Restoring division 2^32 / r2: remainder, quotient and divisor per stage.
	logic [38:0] r2 [NDIV+1];
	logic [39:0] rem [NDIV+1];
	logic [ljpf_pkg::QUO_W:0] quo [NDIV+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			dx[0] <= in_ch.data.dx; dy[0] <= in_ch.data.dy; dz[0] <= in_ch.data.dz;
			skip[0] <= in_ch.data.skip;
			r2[0] <= {1'b0, in_ch.data.sum[ljpf_pkg::SUM_W-1:ljpf_pkg::FRAC_BITS]};
			rem[0] <= '0;
			quo[0] <= '0;
			for (int i = 1; i < NST; i++) begin
				dx[i] <= dx[i-1]; dy[i] <= dy[i-1]; dz[i] <= dz[i-1];
				skip[i] <= skip[i-1];
			end
		end
	end

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		logic [39:0] rr;
		logic [ljpf_pkg::QUO_W:0] qq;
		always_comb begin
			rr = rem[k];
			qq = quo[k];
			for (int j = 0; j < 2; j++) begin
				// Dividend 2^32 has a single set bit, brought in so that it ends
				// up at position 32 after the last step.
				rr = {rr[38:0], (2*k + j == 2*NDIV - N) ? 1'b1 : 1'b0};
				qq = {qq[ljpf_pkg::QUO_W-1:0], 1'b0};
				if (rr >= {1'b0, r2[k]}) begin
					rr = rr - {1'b0, r2[k]};
					qq[0] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem[k+1] <= rr;
				quo[k+1] <= qq;
				r2[k+1] <= r2[k];
			end
		end
	end

	// Stages after the divider; each holds at most one multiply per path.
	logic signed [31:0] q_a, q2_b, q3_c, q4_d, tE_d, tG_d, pE_e, pG_e;
	logic signed [31:0] sE_f, sG_f, e_g, g_g, fx_h, fy_h, fz_h, e_h;
	logic sat_a, sat_b, sat_c, sat_d, sat_e, sat_f, sat_g, sat_h;
	logic signed [31:0] q_b, q_c;
	logic signed [31:0] q3_d;
	logic [32:0] m0, m1, m2, m3, m4, m5, m6, m7, m8, c0, c1, c2, c3;
	logic [32:0] mfx, mfy, mfz;

	// Quotient is at most 2^32 / 1; anything over 31 bits saturates.
	always_comb begin
		m0 = ljpf_pkg::fxmul(q_a, q_a);
		m1 = ljpf_pkg::fxmul(q2_b, q_b);
		m2 = ljpf_pkg::fxmul(q3_c, q_c);
		c0 = ljpf_pkg::clip32(66'(q3_c) - 66'(1 << ljpf_pkg::FRAC_BITS));
		c1 = ljpf_pkg::clip32(66'(1 << ljpf_pkg::FRAC_BITS) - 66'(q3_c) * 2);
		m3 = ljpf_pkg::fxmul(tE_d, q3_d);
		m4 = ljpf_pkg::fxmul(q4_d, tG_d);
		m5 = ljpf_pkg::fxmul($signed({1'b0, cfg.strength}), pE_e);
		m6 = ljpf_pkg::fxmul($signed({1'b0, cfg.strength}), pG_e);
		m7 = ljpf_pkg::clip32(66'(sE_f) * 4);
		m8 = ljpf_pkg::clip32(66'(sG_f) * 24);
		c2 = ljpf_pkg::clip32(66'($signed(m7[31:0])) - 66'(cfg.pot_shift));
		c3 = ljpf_pkg::clip32(66'($signed(m8[31:0])) - 66'(cfg.grad_shift));
		mfx = ljpf_pkg::fxmul(g_g, 32'(dx[NDIV+7]));
		mfy = ljpf_pkg::fxmul(g_g, 32'(dy[NDIV+7]));
		mfz = ljpf_pkg::fxmul(g_g, 32'(dz[NDIV+7]));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage a: saturate the reciprocal.
			if (r2[NDIV] == '0) begin
				q_a <= ljpf_pkg::S32_MAX; sat_a <= 1'b1;
			end else if (quo[NDIV] > (ljpf_pkg::QUO_W+1)'(ljpf_pkg::S32_MAX)) begin
				q_a <= ljpf_pkg::S32_MAX; sat_a <= 1'b1;
			end else begin
				q_a <= $signed(quo[NDIV][31:0]); sat_a <= 1'b0;
			end
			q2_b <= $signed(m0[31:0]); q_b <= q_a; sat_b <= sat_a | m0[32];
			q3_c <= $signed(m1[31:0]); q_c <= q_b; sat_c <= sat_b | m1[32];
			q4_d <= $signed(m2[31:0]); q3_d <= q3_c;
			tE_d <= $signed(c0[31:0]); tG_d <= $signed(c1[31:0]);
			sat_d <= sat_c | m2[32] | c0[32] | c1[32];
			pE_e <= $signed(m3[31:0]); pG_e <= $signed(m4[31:0]);
			sat_e <= sat_d | m3[32] | m4[32];
			sE_f <= $signed(m5[31:0]); sG_f <= $signed(m6[31:0]);
			sat_f <= sat_e | m5[32] | m6[32];
			e_g <= $signed(c2[31:0]); g_g <= $signed(c3[31:0]);
			sat_g <= sat_f | m7[32] | m8[32] | c2[32] | c3[32];
			fx_h <= $signed(mfx[31:0]); fy_h <= $signed(mfy[31:0]);
			fz_h <= $signed(mfz[31:0]); e_h <= e_g;
			sat_h <= sat_g | mfx[32] | mfy[32] | mfz[32];
		end
	end

	always_comb begin
		out_ch.valid = v[NST-1];
		if (skip[NST-1]) begin
			out_ch.data = '0;
		end else begin
			out_ch.data.force_x = fx_h;
			out_ch.data.force_y = fy_h;
			out_ch.data.force_z = fz_h;
			out_ch.data.pair_energy = e_h;
			out_ch.data.interacts = 1'b1;
			out_ch.data.saturated = sat_h;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> v == $past(v))
		else $error("pipeline moved while stalled");
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && skip[NST-1] |-> !out_ch.data.interacts && !out_ch.data.saturated)
		else $error("skipped pair reported interaction");
	a_int: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !skip[NST-1] |-> out_ch.data.interacts)
		else $error("interacting pair not flagged");
endmodule
